### rtl/plen_pkg.sv
// Shared types and constants for the positional list engine.
package plen_pkg;

    localparam int ACTION_W = 1;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 1'b1;

    typedef enum logic [0:0] {
        CTL_IDLE,
        CTL_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic exec;
    } dp_cmd_t;

endpackage

### rtl/plen_if.sv
// Request and response channel interfaces of the positional list engine.
interface plen_req_if;
    logic                                valid;
    logic                                ready;
    logic [plen_pkg::ACTION_W-1:0]       action;
    logic [plen_pkg::POS_W-1:0]          position;
    logic signed [plen_pkg::VALUE_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface plen_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [plen_pkg::VALUE_W-1:0] removed_value;
    logic [plen_pkg::COUNT_W-1:0]        item_count;

    modport source (output valid, output ok, output removed_value, output item_count,
                    input ready);
    modport sink   (input valid, input ok, input removed_value, input item_count,
                    output ready);
endinterface

### rtl/plen_ctrl.sv
// Handshake controller: tracks whether a result is held and issues execute commands.
module plen_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output plen_pkg::dp_cmd_t    cmd
);

    plen_pkg::ctl_state_t state_reg;
    plen_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plen_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plen_pkg::CTL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = plen_pkg::CTL_HOLD;
                end
            end
            plen_pkg::CTL_HOLD:
            begin
                // drop back only when the held result leaves and nothing replaces it
                if (out_ready && !in_valid)
                begin
                    state_next = plen_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = plen_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            plen_pkg::CTL_IDLE:
            begin
                in_ready = 1'b1;
            end
            plen_pkg::CTL_HOLD:
            begin
                in_ready  = out_ready;
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.exec = in_valid && in_ready;
    end

endmodule

### rtl/plen_datapath.sv
// List storage as a chain of shift cells, entry count and result register.
module plen_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plen_pkg::dp_cmd_t                   cmd,
    input  logic [plen_pkg::ACTION_W-1:0]       action,
    input  logic [plen_pkg::POS_W-1:0]          position,
    input  logic signed [plen_pkg::VALUE_W-1:0] value,
    output logic                                ok,
    output logic signed [plen_pkg::VALUE_W-1:0] removed_value,
    output logic [plen_pkg::COUNT_W-1:0]        item_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > plen_pkg::POS_W) ? CW : plen_pkg::POS_W) + 1;
    // only the first entries are reachable by a position field
    localparam int RD = (DEPTH < (1 << plen_pkg::POS_W)) ? DEPTH : (1 << plen_pkg::POS_W);

    logic signed [plen_pkg::VALUE_W-1:0] entries_reg [DEPTH];
    logic signed [plen_pkg::VALUE_W-1:0] entries_next [DEPTH];
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic                                ok_reg;
    logic signed [plen_pkg::VALUE_W-1:0] removed_reg;
    logic [plen_pkg::COUNT_W-1:0]        item_count_reg;

    logic [XW-1:0]                       pos_x;
    logic [XW-1:0]                       cnt_x;
    logic [XW-1:0]                       slot_x;
    logic [plen_pkg::POS_W-1:0]          slot;
    logic                                ins_ok;
    logic                                rem_ok;
    logic                                op_ok;
    logic signed [plen_pkg::VALUE_W-1:0] pick;
    logic [XW-1:0]                       count_x_next;

    always_comb
    begin
        pos_x  = XW'(position);
        cnt_x  = XW'(count_reg);
        slot   = position - plen_pkg::POS_W'(1);
        slot_x = XW'(slot);
        ins_ok = (action == plen_pkg::ACT_INSERT) && (position != '0)
                 && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(DEPTH));
        rem_ok = (action == plen_pkg::ACT_REMOVE) && (position != '0) && (pos_x <= cnt_x);
        op_ok  = ins_ok || rem_ok;

        pick = '0;
        for (int k = 0; k < RD; k++)
        begin
            if (slot == plen_pkg::POS_W'(k))
            begin
                pick = entries_reg[k];
            end
        end

        // each cell looks only at itself and its neighbors
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (ins_ok)
            begin
                if (XW'(i) == slot_x)
                begin
                    entries_next[i] = value;
                end
                else if ((XW'(i) > slot_x) && (i > 0))
                begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (rem_ok)
            begin
                if ((XW'(i) >= slot_x) && (i < DEPTH - 1))
                begin
                    entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end

        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
        count_x_next = XW'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            entries_reg <= entries_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg         <= op_ok;
            removed_reg    <= rem_ok ? pick : '0;
            item_count_reg <= count_x_next[plen_pkg::COUNT_W-1:0];
        end
    end

    assign ok            = ok_reg;
    assign removed_value = removed_reg;
    assign item_count    = item_count_reg;

endmodule

### rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: controller plus list datapath.
//
// Usage:
//   req channel carries one transaction per request: action (insert or remove),
//   a 1-based position and, for an insert, the value. rsp returns exactly one
//   transaction per request: ok, the removed value (zero unless a remove
//   succeeded) and the entry count after the request.
//   All entries behind the position move one place in the same cycle through a
//   chain of shift cells, so a request completes in the cycle it is accepted.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput: one request per cycle; the output register is the only stage.
//   A new request is taken while the held result is consumed in the same cycle.
//   When rsp stalls, the result holds and req.ready drops until it is taken.
//   Reset empties the list (count zero) and leaves no result pending; entry
//   storage is not cleared, since only written entries are ever read.
//   DEPTH sets the list capacity; positions beyond 31 are not addressable and
//   item_count reports the count modulo 32.
module positional_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    plen_req_if.sink    req,
    plen_rsp_if.source  rsp
);

    plen_pkg::dp_cmd_t cmd;

    plen_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    plen_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (req.action),
        .position      (req.position),
        .value         (req.value),
        .ok            (rsp.ok),
        .removed_value (rsp.removed_value),
        .item_count    (rsp.item_count)
    );

endmodule
